FILE: rtl/core/mrob_pkg.sv
// Shared types, register indexes and raster op helpers for the 1bpp blitter.
`default_nettype none

package mrob_pkg;

  localparam int PIX_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_COL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_ROW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd4;

  localparam logic [6:0] MODE_AND_A  = 7'd0;
  localparam logic [6:0] MODE_OR     = 7'd1;
  localparam logic [6:0] MODE_COPY_A = 7'd2;
  localparam logic [6:0] MODE_XOR    = 7'd3;
  localparam logic [6:0] MODE_AND_B  = 7'd4;
  localparam logic [6:0] MODE_COPY_B = 7'd5;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_COPY = 3'd1,
    OP_AND  = 3'd2,
    OP_OR   = 3'd3,
    OP_XOR  = 3'd4
  } op_t;

  typedef struct packed {
    logic [5:0]        origin_col;
    logic signed [8:0] origin_row;
    logic [7:0]        width;
    logic [7:0]        height;
    logic [6:0]        mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0]       row;
    logic [8:0]       col;
    logic [PIX_W-1:0] img;
    op_t              op;
    logic             wr;
    logic             eoi;
  } req_t;

  typedef struct packed {
    logic [7:0]       screen_row;
    logic [8:0]       screen_column_byte;
    logic [PIX_W-1:0] pixel_bits;
    logic             was_written;
    logic             end_of_image;
  } res_t;

  function automatic op_t decode_op(input logic [6:0] mode);
    op_t op;
    unique case (mode)
      MODE_COPY_A, MODE_COPY_B: op = OP_COPY;
      MODE_AND_A, MODE_AND_B:   op = OP_AND;
      MODE_OR:                  op = OP_OR;
      MODE_XOR:                 op = OP_XOR;
      default:                  op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic logic [PIX_W-1:0] apply_op(input op_t op,
                                                input logic [PIX_W-1:0] img,
                                                input logic [PIX_W-1:0] old);
    logic [PIX_W-1:0] res;
    unique case (op)
      OP_COPY: res = img;
      OP_AND:  res = img & old;
      OP_OR:   res = img | old;
      OP_XOR:  res = img ^ old;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mrob_ifs.sv
// Valid/ready channel interfaces for image beats, result beats and config writes.
`default_nettype none

interface mrob_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] image_byte;

  modport source (output valid, output image_byte, input ready);
  modport sink (input valid, input image_byte, output ready);
endinterface

interface mrob_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] screen_row;
  logic [8:0] screen_column_byte;
  logic [6:0] pixel_bits;
  logic       was_written;
  logic       end_of_image;

  modport source (output valid, output screen_row, output screen_column_byte,
                  output pixel_bits, output was_written, output end_of_image,
                  input ready);
  modport sink (input valid, input screen_row, input screen_column_byte,
                input pixel_bits, input was_written, input end_of_image,
                output ready);
endinterface

interface mrob_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [8:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/mrob_walk.sv
// Image row/column walker: target position, clipping, op decode and store address.
`default_nettype none

module mrob_walk #(
  parameter int SCREEN_ROWS  = 192,
  parameter int SCREEN_BYTES = 40,
  parameter int AW           = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          image_byte,
  input  mrob_pkg::cfg_t      cfg,
  output mrob_pkg::req_t      req,
  output logic [AW-1:0]       addr
);
  import mrob_pkg::*;

  logic [7:0]        row_cnt_r;
  logic [7:0]        row_cnt_nxt;
  logic [7:0]        col_cnt_r;
  logic [7:0]        col_cnt_nxt;
  logic signed [9:0] row_s;
  logic [8:0]        col;
  logic              on_screen;
  logic              last_col;
  logic              last_row;
  logic [15:0]       row_base;
  logic [15:0]       lin_addr;
  op_t               op;

  assign row_s     = {cfg.origin_row[8], cfg.origin_row} + {2'b00, row_cnt_r};
  assign col       = {3'b000, cfg.origin_col} + {1'b0, col_cnt_r};
  assign on_screen = !row_s[9] && (row_s[8:0] < 9'(SCREEN_ROWS)) &&
                     (col < 9'(SCREEN_BYTES));
  assign last_col  = ({1'b0, col_cnt_r} + 9'd1) >= {1'b0, cfg.width};
  assign last_row  = ({1'b0, row_cnt_r} + 9'd1) >= {1'b0, cfg.height};
  assign row_base  = 16'(row_s[7:0]) * 16'(SCREEN_BYTES);
  assign lin_addr  = row_base + {10'd0, col[5:0]};
  assign addr      = lin_addr[AW-1:0];
  assign op        = decode_op(cfg.mode);

  always_comb begin
    req.row = row_s[7:0];
    req.col = col;
    req.img = image_byte[PIX_W-1:0];
    req.op  = op;
    req.wr  = on_screen && (op != OP_NONE);
    req.eoi = last_col && last_row;
  end

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    if (fire) begin
      if (last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last_row ? 8'd0 : row_cnt_r + 8'd1;
      end else begin
        col_cnt_nxt = col_cnt_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else begin
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/mrob_fstore.sv
// Frame store with clearing sweep, read-modify-write stage and result register.
`default_nettype none

module mrob_fstore #(
  parameter int SCREEN_ROWS  = 192,
  parameter int SCREEN_BYTES = 40,
  parameter int AW           = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mrob_pkg::req_t      req,
  input  logic [AW-1:0]       addr,
  output logic                out_valid,
  input  logic                out_ready,
  output mrob_pkg::res_t      res
);
  import mrob_pkg::*;

  localparam int DEPTH = SCREEN_ROWS * SCREEN_BYTES;

  logic [PIX_W-1:0] mem [DEPTH];

  logic             clr_r;
  logic [AW-1:0]    clr_addr_r;
  logic             s1_valid_r;
  req_t             s1_req_r;
  logic [AW-1:0]    s1_addr_r;
  logic [PIX_W-1:0] rdata_r;
  logic             fwd_hit_r;
  logic [PIX_W-1:0] fwd_data_r;
  logic             out_valid_r;
  res_t             out_r;

  logic             s1_go;
  logic             fire;
  logic             wr_en;
  logic [PIX_W-1:0] old_pix;
  logic [PIX_W-1:0] new_pix;

  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_r && (!s1_valid_r || s1_go);
  assign fire     = in_valid && in_ready;
  assign old_pix  = fwd_hit_r ? fwd_data_r : rdata_r;
  assign new_pix  = apply_op(s1_req_r.op, s1_req_r.img, old_pix);
  assign wr_en    = s1_go && s1_req_r.wr;

  assign out_valid = out_valid_r;
  assign res       = out_r;

  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[s1_addr_r] <= new_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // write-back landing on the same edge as the next read is forwarded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (fire) begin
      fwd_hit_r <= wr_en && (s1_addr_r == addr);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      fwd_data_r <= new_pix;
      s1_req_r   <= req;
      s1_addr_r  <= addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_r.screen_row         <= s1_req_r.row;
      out_r.screen_column_byte <= s1_req_r.col;
      out_r.pixel_bits         <= s1_req_r.wr ? new_pix : '0;
      out_r.was_written        <= s1_req_r.wr;
      out_r.end_of_image       <= s1_req_r.eoi;
    end
  end

`ifndef SYNTHESIS
  a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> (!in_ready && !s1_valid_r))
    else $error("beat accepted during frame store clear");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |-> !in_ready)
    else $error("input taken while modify stage is stalled");

  a_fwd_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
    (fire ##1 fwd_hit_r) |-> $past(wr_en))
    else $error("forward hit without a write-back");

  a_skipped_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.was_written) |-> (out_r.pixel_bits == '0))
    else $error("unwritten beat carries pixels");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/monochrome_raster_op_blitter_core.sv
// Top level of the 1bpp raster op blitter: config registers and channel wiring.
`default_nettype none

// Takes one image byte per cycle while not clearing and the result side is not
// stalled, and returns one result beat per byte, registered through the modify stage
// and the result register. The input side walks the image counters, works out the
// screen address and reads the frame store; the modify stage applies the raster op
// and writes the byte back, with the previous write-back forwarded when consecutive
// bytes hit the same entry. The frame store has one read and one write port, so the
// read of one byte overlaps the write-back of the one before it, holding one byte per
// cycle when unstalled. After reset the frame store is cleared one entry a cycle,
// SCREEN_ROWS*SCREEN_BYTES entries (7680 by default), taking no image beats; config
// writes are always taken and must only be issued while no image is in flight.
module monochrome_raster_op_blitter_core #(
  parameter int SCREEN_ROWS  = 192,
  parameter int SCREEN_BYTES = 40
) (
  input  logic              clk,
  input  logic              rst_n,
  mrob_in_if.sink           in_bus,
  mrob_out_if.source        out_bus,
  mrob_cfg_if.sink          cfg_bus
);
  import mrob_pkg::*;

  localparam int DEPTH = SCREEN_ROWS * SCREEN_BYTES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t          cfg_r;
  req_t          req;
  res_t          res;
  logic [AW-1:0] addr;
  logic          in_ready;
  logic          fire;

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = in_ready;
  assign fire          = in_bus.valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_col <= '0;
      cfg_r.origin_row <= '0;
      cfg_r.width      <= 8'd1;
      cfg_r.height     <= 8'd1;
      cfg_r.mode       <= MODE_COPY_A;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        REG_ORIGIN_COL: cfg_r.origin_col <= cfg_bus.data[5:0];
        REG_ORIGIN_ROW: cfg_r.origin_row <= cfg_bus.data[8:0];
        REG_WIDTH:      cfg_r.width      <= cfg_bus.data[7:0];
        REG_HEIGHT:     cfg_r.height     <= cfg_bus.data[7:0];
        REG_MODE:       cfg_r.mode       <= cfg_bus.data[6:0];
        default: ;
      endcase
    end
  end

  mrob_walk #(
    .SCREEN_ROWS  (SCREEN_ROWS),
    .SCREEN_BYTES (SCREEN_BYTES),
    .AW           (AW)
  ) u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .image_byte (in_bus.image_byte),
    .cfg        (cfg_r),
    .req        (req),
    .addr       (addr)
  );

  mrob_fstore #(
    .SCREEN_ROWS  (SCREEN_ROWS),
    .SCREEN_BYTES (SCREEN_BYTES),
    .AW           (AW)
  ) u_fstore (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_ready),
    .req       (req),
    .addr      (addr),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .res       (res)
  );

  assign out_bus.screen_row         = res.screen_row;
  assign out_bus.screen_column_byte = res.screen_column_byte;
  assign out_bus.pixel_bits         = res.pixel_bits;
  assign out_bus.was_written        = res.was_written;
  assign out_bus.end_of_image       = res.end_of_image;

endmodule

`default_nettype wire
